>>> sv/dfpa_pkg.sv
// shared types and constants for the decimal fixed-point alu
`default_nettype none
package dfpa_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  localparam logic [63:0] DEC_SCALE = 64'd1000000000000;
  localparam logic [63:0] SIGN_BIT  = 64'h8000000000000000;
  localparam logic [63:0] POS_MAX   = 64'h7FFFFFFFFFFFFFFF;

  // 10^12 = 2^12 * 5^12, the odd part is divided out by a reciprocal scaled by 2^120
  localparam logic [127:0] SCALE_ODD = 128'd244140625;
  localparam logic [127:0] RECIP_ODD = ((128'd1 << 120) + SCALE_ODD - 128'd1) / SCALE_ODD;

  // products at or above this give a quotient beyond 2^63 and saturate for either sign
  localparam logic [127:0] MUL_OVF_LIMIT = ({64'd0, DEC_SCALE} << 63) + {64'd0, DEC_SCALE};

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic        neg;
    logic        dz;
    logic        less;
    logic        equal;
    logic        greater;
  } entry_t;

  typedef struct packed {
    logic [63:0] value;
    logic        less;
    logic        equal;
    logic        greater;
    logic        ovf;
    logic        dz;
  } result_t;

endpackage
`default_nettype wire

>>> sv/decimal_fixed_point_alu.sv
// top level of the decimal fixed-point alu
// Signed 64-bit values scaled by 10^12. Add, subtract and divide by zero are worked
// out combinationally in the back end and sustain one transaction per cycle while the
// output is not stalled; the result is registered as the entry leaves the queue.
// Multiply forms the 128-bit product on a shared 32x32 multiplier and divides it by
// 10^12 with a reciprocal multiply, which is skipped when the product is out of
// range. Divide forms |a|*10^12 and then runs a restoring divider; a divisor of
// magnitude 2^63 skips the divider. A stalled output holds the back end. A queue
// of DEPTH entries lets the input keep accepting while the back end is busy;
// results leave in input order.
`default_nettype none
module decimal_fixed_point_alu
  import dfpa_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      result_value,
  output logic             less_flag,
  output logic             equal_flag,
  output logic             greater_flag,
  output logic             overflow_flag,
  output logic             divide_by_zero_flag
);

  entry_t  f_ent;
  entry_t  q_data;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  result_t res;

  assign in_stall = q_full;

  dfpa_front u_front (
    .cmd       (cmd),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .ent       (f_ent)
  );

  dfpa_queue #(.DEPTH(DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (in_valid && !q_full),
    .wdata (f_ent),
    .pop   (q_pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  dfpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign result_value        = res.value;
  assign less_flag           = res.less;
  assign equal_flag          = res.equal;
  assign greater_flag        = res.greater;
  assign overflow_flag       = res.ovf;
  assign divide_by_zero_flag = res.dz;

endmodule
`default_nettype wire

>>> sv/dfpa_front.sv
// front end: classifies a transaction and works out flags and magnitudes
`default_nettype none
module dfpa_front
  import dfpa_pkg::*;
(
  input  wire logic [1:0]  cmd,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  output entry_t           ent
);

  always_comb begin
    ent.cmd     = cmd_t'(cmd);
    ent.a       = operand_a;
    ent.b       = operand_b;
    ent.mag_a   = operand_a[63] ? (64'd0 - operand_a) : operand_a;
    ent.mag_b   = operand_b[63] ? (64'd0 - operand_b) : operand_b;
    ent.neg     = operand_a[63] ^ operand_b[63];
    ent.dz      = (cmd_t'(cmd) == CMD_DIV) && (operand_b == 64'd0);
    ent.less    = $signed(operand_a) < $signed(operand_b);
    ent.equal   = operand_a == operand_b;
    ent.greater = $signed(operand_a) > $signed(operand_b);
  end

endmodule
`default_nettype wire

>>> sv/dfpa_queue.sv
// small queue between front and back end
`default_nettype none
module dfpa_queue
  import dfpa_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t wdata,
  input  wire logic   pop,
  output entry_t      rdata,
  output logic        full,
  output logic        empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule
`default_nettype wire

>>> sv/dfpa_back.sv
// back end: add and subtract in one step, shared multiplier and divider
`default_nettype none
module dfpa_back
  import dfpa_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_empty,
  input  wire entry_t q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output result_t     res
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_RECIP, S_DIV, S_SAT} state_t;

  state_t        state;
  entry_t        ent;
  logic [6:0]    step;
  logic [1:0]    xi;
  logic [1:0]    yi;
  logic [1:0]    lim;
  logic [95:0]   mx;
  logic [95:0]   my;
  logic [63:0]   dvs;
  logic [191:0]  acc;
  logic [127:0]  quo;
  logic [63:0]   rem;
  logic          out_free;
  logic          fast_class;
  logic          fast_load;
  logic          slow_load;
  logic          mul_last;
  logic [2:0]    pos;
  logic [63:0]   part_x;
  logic [63:0]   part_y;
  logic [63:0]   partial;
  logic [191:0]  part_sh;
  logic [191:0]  acc_sum;
  logic [64:0]   trial;
  logic [63:0]   sum;
  logic [63:0]   diff;
  result_t       fast;
  result_t       slow;

  assign out_free   = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && !q_empty && out_free;
  assign fast_class = (q_data.cmd inside {CMD_ADD, CMD_SUB}) || q_data.dz;
  assign fast_load  = q_pop && fast_class;
  assign slow_load  = (state == S_SAT) && out_free;
  assign mul_last   = (xi == lim) && (yi == lim);

  always_comb begin
    case (xi)
      2'd0:    part_x = {32'd0, mx[31:0]};
      2'd1:    part_x = {32'd0, mx[63:32]};
      default: part_x = {32'd0, mx[95:64]};
    endcase
    case (yi)
      2'd0:    part_y = {32'd0, my[31:0]};
      2'd1:    part_y = {32'd0, my[63:32]};
      default: part_y = {32'd0, my[95:64]};
    endcase
    partial = part_x * part_y;
    pos     = {1'b0, xi} + {1'b0, yi};
    case (pos)
      3'd0:    part_sh = {128'd0, partial};
      3'd1:    part_sh = {96'd0, partial, 32'd0};
      3'd2:    part_sh = {64'd0, partial, 64'd0};
      3'd3:    part_sh = {32'd0, partial, 96'd0};
      default: part_sh = {partial, 128'd0};
    endcase
    acc_sum = acc + part_sh;
    trial   = {rem, acc[127]};
  end

  always_comb begin
    sum  = q_data.a + q_data.b;
    diff = q_data.a - q_data.b;
    fast.less    = q_data.less;
    fast.equal   = q_data.equal;
    fast.greater = q_data.greater;
    fast.dz      = q_data.dz;
    fast.ovf     = 1'b0;
    fast.value   = 64'd0;
    case (q_data.cmd)
      CMD_ADD: begin
        fast.ovf   = ((q_data.a ^ sum) & (q_data.b ^ sum) & SIGN_BIT) != 64'd0;
        fast.value = fast.ovf ? (q_data.a[63] ? SIGN_BIT : POS_MAX) : sum;
      end
      CMD_SUB: begin
        fast.ovf   = ((q_data.a ^ q_data.b) & (q_data.a ^ diff) & SIGN_BIT) != 64'd0;
        fast.value = fast.ovf ? (q_data.a[63] ? SIGN_BIT : POS_MAX) : diff;
      end
      default: begin
        fast.value = 64'd0;
      end
    endcase
  end

  always_comb begin
    slow.less    = ent.less;
    slow.equal   = ent.equal;
    slow.greater = ent.greater;
    slow.dz      = 1'b0;
    if (ent.neg) begin
      slow.ovf   = (quo[127:64] != 64'd0) || (quo[63:0] > SIGN_BIT);
      slow.value = slow.ovf ? SIGN_BIT : (64'd0 - quo[63:0]);
    end else begin
      slow.ovf   = (quo[127:64] != 64'd0) || (quo[63:0] > POS_MAX);
      slow.value = slow.ovf ? POS_MAX : quo[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (fast_load || slow_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (fast_load) begin
        res <= fast;
      end else if (slow_load) begin
        res <= slow;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            ent <= q_data;
            if (!fast_class) begin
              mx    <= {32'd0, q_data.mag_a};
              my    <= {32'd0, (q_data.cmd == CMD_MUL) ? q_data.mag_b : DEC_SCALE};
              dvs   <= q_data.mag_b;
              acc   <= '0;
              xi    <= '0;
              yi    <= '0;
              lim   <= 2'd1;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_last) begin
            xi <= '0;
            yi <= '0;
            if (ent.cmd == CMD_MUL) begin
              if (acc_sum[127:0] >= MUL_OVF_LIMIT) begin
                quo   <= '1;
                state <= S_SAT;
              end else begin
                // drop the factor 2^12 first, then the odd part by reciprocal
                mx    <= acc_sum[107:12];
                my    <= RECIP_ODD[95:0];
                acc   <= '0;
                lim   <= 2'd2;
                state <= S_RECIP;
              end
            end else if (dvs == SIGN_BIT) begin
              quo   <= acc_sum[127:0] >> 63;
              state <= S_SAT;
            end else begin
              acc   <= acc_sum;
              rem   <= '0;
              step  <= '0;
              state <= S_DIV;
            end
          end else begin
            acc <= acc_sum;
            if (xi == lim) begin
              xi <= '0;
              yi <= yi + 1'b1;
            end else begin
              xi <= xi + 1'b1;
            end
          end
        end
        S_RECIP: begin
          if (mul_last) begin
            quo   <= {64'd0, acc_sum[183:120]};
            state <= S_SAT;
          end else begin
            acc <= acc_sum;
            if (xi == lim) begin
              xi <= '0;
              yi <= yi + 1'b1;
            end else begin
              xi <= xi + 1'b1;
            end
          end
        end
        S_DIV: begin
          acc  <= {acc[190:0], 1'b0};
          step <= step + 1'b1;
          if (trial >= {1'b0, dvs}) begin
            rem <= 64'(trial - {1'b0, dvs});
            quo <= {quo[126:0], 1'b1};
          end else begin
            rem <= trial[63:0];
            quo <= {quo[126:0], 1'b0};
          end
          if (step == 7'd127) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({res.less, res.equal, res.greater}))
    else $error("comparison flags not one-hot");

  a_ovf_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res.ovf && res.dz))
    else $error("overflow and divide by zero both set");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE) && out_free)
    else $error("pop outside idle");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && step == 7'd127) |=> state == S_SAT)
    else $error("divider did not finish");

endmodule
`default_nettype wire
